[hw/rtl/sall_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sall_pkg;

   localparam int SLOTS      = 16;
   localparam int VALUE_BITS = 16;
   localparam int IDX_BITS   = $clog2(SLOTS);
   localparam int STEP_BITS  = $clog2(SLOTS + 1);

   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [STEP_BITS-1:0]         step_type;
   typedef logic [1:0]                   status_type;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   // Result status codes
   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;
   localparam status_type ST_EMPTY     = 2'd3;

   // Read address sources
   typedef enum logic [1:0] {
      RA_FHEAD,
      RA_HEAD,
      RA_TAIL,
      RA_NEXT
   } rd_sel_type;

   // Link write address sources
   typedef enum logic [2:0] {
      WA_S,
      WA_TAIL,
      WA_PREV,
      WA_HEAD,
      WA_CUR,
      WA_FTAIL
   } wa_sel_type;

   // Link write data sources
   typedef enum logic [2:0] {
      WD_ZERO,
      WD_HEAD,
      WD_S,
      WD_CUR,
      WD_NEXT,
      WD_FHEAD
   } wd_sel_type;

   typedef enum logic [1:0] {
      HD_HOLD,
      HD_S,
      HD_NEXT
   } head_sel_type;

   typedef enum logic [1:0] {
      TL_HOLD,
      TL_S,
      TL_PREV,
      TL_ZERO
   } tail_sel_type;

   typedef enum logic [1:0] {
      FH_HOLD,
      FH_NEXT,
      FH_HEAD,
      FH_CUR
   } fh_sel_type;

   typedef enum logic [1:0] {
      FT_HOLD,
      FT_ZERO,
      FT_HEAD,
      FT_CUR
   } ft_sel_type;

   typedef enum logic [1:0] {
      WK_HOLD,
      WK_START,
      WK_STEP
   } walk_sel_type;

   typedef enum logic [1:0] {
      SL_ZERO,
      SL_S,
      SL_HEAD,
      SL_CUR
   } slot_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic         latch_req;
      rd_sel_type   link_ra;
      rd_sel_type   val_ra;
      logic         link_we;
      wa_sel_type   link_wa;
      wd_sel_type   link_wd;
      logic         val_we;
      logic         s_load;
      head_sel_type head_sel;
      tail_sel_type tail_sel;
      fh_sel_type   fh_sel;
      ft_sel_type   ft_sel;
      walk_sel_type walk;
      logic         res_load;
      status_type   res_status;
      slot_sel_type res_slot;
      logic         out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic in_op;
      logic fhead_zero;
      logic head_zero;
      logic ftail_zero;
      logic next_zero;
      logic cur_zero;
      logic cur_is_tail;
      logic steps_max;
      logic k_gt_rv;
      logic k_eq_rv;
      logic out_free;
   } dp_status_type;

   // Any index at or above the slot count reads as none
   function automatic idx_type clamp_idx(input idx_type i);
      return (int'(i) < SLOTS) ? i : '0;
   endfunction

   // Link of a slot that was never written: the free chain of reset
   function automatic idx_type link_reset_value(input idx_type i);
      return ((i == '0) || (int'(i) + 1 >= SLOTS)) ? '0 : IDX_BITS'(int'(i) + 1);
   endfunction

endpackage

`default_nettype wire

[hw/rtl/sall_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one list operation per transfer
interface sall_req_if;
   import sall_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   value_type value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// Response channel: one result per operation
interface sall_rsp_if;
   import sall_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   idx_type    slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[hw/rtl/sall_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sall_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/sall_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sall_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sall_pkg::dp_status_type status,
   output sall_pkg::dp_cmd_type         cmd
);

   import sall_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_INS0       = 4'd1;
   localparam logic [3:0] S_INS1       = 4'd2;
   localparam logic [3:0] S_INS2       = 4'd3;
   localparam logic [3:0] S_INS_TAIL   = 4'd4;
   localparam logic [3:0] S_INS_WALK   = 4'd5;
   localparam logic [3:0] S_INS_FIX    = 4'd6;
   localparam logic [3:0] S_DEL0       = 4'd7;
   localparam logic [3:0] S_DEL1       = 4'd8;
   localparam logic [3:0] S_DEL_WALK   = 4'd9;
   localparam logic [3:0] S_DEL_UNLINK = 4'd10;
   localparam logic [3:0] S_DEL_FREE   = 4'd11;
   localparam logic [3:0] S_RESP       = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       ins_more;
   logic       del_more;

   // Walk continues while the current element exists, is smaller than the key and the step limit is not reached
   assign ins_more = !status.cur_zero && status.k_gt_rv && !status.steps_max;
   assign del_more = ins_more;

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one operation
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = (status.in_op == OP_DELETE) ? S_DEL0 : S_INS0;
            end
         end
         S_INS0: begin
            cmd.link_ra = RA_FHEAD;
            cmd.val_ra  = RA_HEAD;
            if (status.fhead_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_FULL;
               cmd.res_slot   = SL_ZERO;
               state_in       = S_RESP;
            end else begin
               cmd.s_load = 1'b1;
               state_in   = S_INS1;
            end
         end
         S_INS1: begin
            // take the free head and store the value
            cmd.fh_sel  = FH_NEXT;
            cmd.ft_sel  = status.next_zero ? FT_ZERO : FT_HOLD;
            cmd.val_we  = 1'b1;
            cmd.val_ra  = RA_TAIL;
            cmd.link_ra = RA_HEAD;
            if (status.head_zero) begin
               cmd.link_we    = 1'b1;
               cmd.link_wa    = WA_S;
               cmd.link_wd    = WD_ZERO;
               cmd.head_sel   = HD_S;
               cmd.tail_sel   = TL_S;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_DONE;
               cmd.res_slot   = SL_S;
               state_in       = S_RESP;
            end else if (!status.k_gt_rv) begin
               cmd.link_we    = 1'b1;
               cmd.link_wa    = WA_S;
               cmd.link_wd    = WD_HEAD;
               cmd.head_sel   = HD_S;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_DONE;
               cmd.res_slot   = SL_S;
               state_in       = S_RESP;
            end else begin
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            if (status.k_gt_rv) begin
               cmd.link_we = 1'b1;
               cmd.link_wa = WA_S;
               cmd.link_wd = WD_ZERO;
               state_in    = S_INS_TAIL;
            end else begin
               cmd.walk    = WK_START;
               cmd.link_ra = RA_NEXT;
               cmd.val_ra  = RA_NEXT;
               state_in    = S_INS_WALK;
            end
         end
         S_INS_TAIL: begin
            cmd.link_we    = 1'b1;
            cmd.link_wa    = WA_TAIL;
            cmd.link_wd    = WD_S;
            cmd.tail_sel   = TL_S;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.res_slot   = SL_S;
            state_in       = S_RESP;
         end
         S_INS_WALK: begin
            if (ins_more) begin
               cmd.walk    = WK_STEP;
               cmd.link_ra = RA_NEXT;
               cmd.val_ra  = RA_NEXT;
            end else begin
               cmd.link_we = 1'b1;
               cmd.link_wa = WA_S;
               cmd.link_wd = WD_CUR;
               state_in    = S_INS_FIX;
            end
         end
         S_INS_FIX: begin
            cmd.link_we    = 1'b1;
            cmd.link_wa    = WA_PREV;
            cmd.link_wd    = WD_S;
            cmd.tail_sel   = status.cur_zero ? TL_S : TL_HOLD;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.res_slot   = SL_S;
            state_in       = S_RESP;
         end
         S_DEL0: begin
            cmd.link_ra = RA_HEAD;
            cmd.val_ra  = RA_HEAD;
            if (status.head_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_EMPTY;
               cmd.res_slot   = SL_ZERO;
               state_in       = S_RESP;
            end else begin
               state_in = S_DEL1;
            end
         end
         S_DEL1: begin
            if (status.k_eq_rv) begin
               // unlink the head and push it on the free head
               cmd.link_we    = 1'b1;
               cmd.link_wa    = WA_HEAD;
               cmd.link_wd    = WD_FHEAD;
               cmd.head_sel   = HD_NEXT;
               cmd.tail_sel   = status.next_zero ? TL_ZERO : TL_HOLD;
               cmd.fh_sel     = FH_HEAD;
               cmd.ft_sel     = status.ftail_zero ? FT_HEAD : FT_HOLD;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_DONE;
               cmd.res_slot   = SL_HEAD;
               state_in       = S_RESP;
            end else begin
               cmd.walk    = WK_START;
               cmd.link_ra = RA_NEXT;
               cmd.val_ra  = RA_NEXT;
               state_in    = S_DEL_WALK;
            end
         end
         S_DEL_WALK: begin
            if (del_more) begin
               cmd.walk    = WK_STEP;
               cmd.link_ra = RA_NEXT;
               cmd.val_ra  = RA_NEXT;
            end else if (status.cur_zero || !status.k_eq_rv) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               cmd.res_slot   = SL_ZERO;
               state_in       = S_RESP;
            end else begin
               cmd.link_we  = 1'b1;
               cmd.link_wa  = WA_PREV;
               cmd.link_wd  = WD_NEXT;
               cmd.tail_sel = status.cur_is_tail ? TL_PREV : TL_HOLD;
               state_in     = S_DEL_UNLINK;
            end
         end
         S_DEL_UNLINK: begin
            cmd.link_we = 1'b1;
            cmd.link_wa = WA_CUR;
            cmd.link_wd = WD_ZERO;
            state_in    = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            // append the freed slot at the free tail
            if (status.ftail_zero) begin
               cmd.fh_sel = FH_CUR;
            end else begin
               cmd.link_we = 1'b1;
               cmd.link_wa = WA_FTAIL;
               cmd.link_wd = WD_CUR;
            end
            cmd.ft_sel     = FT_CUR;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_DONE;
            cmd.res_slot   = SL_CUR;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sall_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module sall_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sall_pkg::dp_cmd_type cmd,
   output sall_pkg::dp_status_type   status,
   input  wire logic                 in_op,
   input  wire sall_pkg::value_type  in_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sall_pkg::status_type      rsp_status,
   output sall_pkg::idx_type         rsp_slot
);

   import sall_pkg::*;

   // List and free list pointers
   idx_type    head_ff, head_in;
   idx_type    tail_ff, tail_in;
   idx_type    fhead_ff, fhead_in;
   idx_type    ftail_ff, ftail_in;

   // Operation and walk registers
   logic       op_ff;
   value_type  val_ff;
   idx_type    s_ff;
   idx_type    prev_ff;
   idx_type    cur_ff;
   step_type   steps_ff;

   // Result and output registers
   status_type res_status_ff;
   idx_type    res_slot_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   idx_type    rsp_slot_ff;

   // Link store bookkeeping
   logic [SLOTS-1:0] valid_ff;
   idx_type    link_raddr_ff;
   logic       link_rvalid_ff;

   idx_type    link_raddr;
   idx_type    val_raddr;
   idx_type    link_waddr;
   idx_type    link_wdata;
   idx_type    link_q;
   logic [VALUE_BITS-1:0] val_q;
   value_type  rval;
   idx_type    next;
   idx_type    res_slot;

   function automatic idx_type pick_rd(input rd_sel_type sel, input idx_type fh,
                                       input idx_type hd, input idx_type tl,
                                       input idx_type nx);
      case (sel)
         RA_FHEAD: return fh;
         RA_HEAD:  return hd;
         RA_TAIL:  return tl;
         RA_NEXT:  return nx;
         default:  return '0;
      endcase
   endfunction

   // Never-written link entries read as the reset free chain
   assign next = clamp_idx(link_rvalid_ff ? link_q : link_reset_value(link_raddr_ff));
   assign rval = $signed(val_q);

   assign link_raddr = pick_rd(cmd.link_ra, fhead_ff, head_ff, tail_ff, next);
   assign val_raddr  = pick_rd(cmd.val_ra, fhead_ff, head_ff, tail_ff, next);

   // Select link write address and data
   always_comb begin
      case (cmd.link_wa)
         WA_S:     link_waddr = s_ff;
         WA_TAIL:  link_waddr = tail_ff;
         WA_PREV:  link_waddr = prev_ff;
         WA_HEAD:  link_waddr = head_ff;
         WA_CUR:   link_waddr = cur_ff;
         WA_FTAIL: link_waddr = ftail_ff;
         default:  link_waddr = '0;
      endcase
      case (cmd.link_wd)
         WD_ZERO:  link_wdata = '0;
         WD_HEAD:  link_wdata = head_ff;
         WD_S:     link_wdata = s_ff;
         WD_CUR:   link_wdata = cur_ff;
         WD_NEXT:  link_wdata = next;
         WD_FHEAD: link_wdata = fhead_ff;
         default:  link_wdata = '0;
      endcase
   end

   sall_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (SLOTS)
   ) link_ram (
      .clock   (clock),
      .wr_en   (cmd.link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_q)
   );

   sall_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (SLOTS)
   ) value_ram (
      .clock   (clock),
      .wr_en   (cmd.val_we),
      .wr_addr (s_ff),
      .wr_data (val_ff),
      .rd_addr (val_raddr),
      .rd_data (val_q)
   );

   // Pointer updates
   always_comb begin
      case (cmd.head_sel)
         HD_S:    head_in = s_ff;
         HD_NEXT: head_in = next;
         default: head_in = head_ff;
      endcase
      case (cmd.tail_sel)
         TL_S:    tail_in = s_ff;
         TL_PREV: tail_in = prev_ff;
         TL_ZERO: tail_in = '0;
         default: tail_in = tail_ff;
      endcase
      case (cmd.fh_sel)
         FH_NEXT: fhead_in = next;
         FH_HEAD: fhead_in = head_ff;
         FH_CUR:  fhead_in = cur_ff;
         default: fhead_in = fhead_ff;
      endcase
      case (cmd.ft_sel)
         FT_ZERO: ftail_in = '0;
         FT_HEAD: ftail_in = head_ff;
         FT_CUR:  ftail_in = cur_ff;
         default: ftail_in = ftail_ff;
      endcase
      case (cmd.res_slot)
         SL_S:    res_slot = s_ff;
         SL_HEAD: res_slot = head_ff;
         SL_CUR:  res_slot = cur_ff;
         default: res_slot = '0;
      endcase
   end

   // Hold the result until the output side takes it
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fhead_ff     <= IDX_BITS'(1);
         ftail_ff     <= IDX_BITS'(SLOTS - 1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fhead_ff     <= fhead_in;
         ftail_ff     <= ftail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.link_we) begin
            valid_ff[link_waddr] <= 1'b1;
         end
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      link_raddr_ff  <= link_raddr;
      link_rvalid_ff <= valid_ff[link_raddr];
      if (cmd.latch_req) begin
         op_ff  <= in_op;
         val_ff <= in_value;
      end
      if (cmd.s_load) begin
         s_ff <= fhead_ff;
      end
      case (cmd.walk)
         WK_START: begin
            prev_ff  <= head_ff;
            cur_ff   <= next;
            steps_ff <= '0;
         end
         WK_STEP: begin
            prev_ff  <= cur_ff;
            cur_ff   <= next;
            steps_ff <= steps_ff + STEP_BITS'(1);
         end
         default: begin
         end
      endcase
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= res_slot;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
      end
   end

   // Status for the controller
   always_comb begin
      status.in_op       = in_op;
      status.fhead_zero  = (fhead_ff == '0);
      status.head_zero   = (head_ff == '0);
      status.ftail_zero  = (ftail_ff == '0);
      status.next_zero   = (next == '0);
      status.cur_zero    = (cur_ff == '0);
      status.cur_is_tail = (cur_ff == tail_ff);
      status.steps_max   = (steps_ff == STEP_BITS'(SLOTS));
      status.k_gt_rv     = (val_ff > rval);
      status.k_eq_rv     = (val_ff == rval) && (op_ff == OP_DELETE);
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

[hw/rtl/sorted_array_linked_list.sv]
// From request transfer to rsp valid, the path depends on the case: a full store or an
// empty-list delete decides at the first check, an insert at the head or into an empty list
// or a delete of the head at the head compare, the others after the tail compare or a walk.
// Throughput: one operation at a time; the next request is taken the cycle after the result
// moves to the output register. Synchronous reset empties the list and chains slots 1..15
// free at once through per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_linked_list (
   input wire logic    clock,
   input wire logic    reset,
   sall_req_if.sink    req_ch,
   sall_rsp_if.source  rsp_ch
);

   import sall_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   sall_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sall_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_op      (req_ch.op),
      .in_value   (req_ch.value),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_status (rsp_ch.status),
      .rsp_slot   (rsp_ch.slot)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

import sall_pkg::*;

typedef struct {
   status_type status;
   idx_type    slot;
} list_result_type;

// Mirror of the slot store: predicts each result and checks the responses
class list_mirror;
   value_type       vals[SLOTS];
   idx_type         links[SLOTS];
   idx_type         head;
   idx_type         tail;
   idx_type         fhead;
   idx_type         ftail;
   list_result_type expected_results[$];
   int              errors;
   int              n_insert;
   int              n_delete;
   int              n_status[4];

   function new();
      for (int i = 0; i < SLOTS; i++) begin
         vals[i]  = '0;
         links[i] = (i == 0 || i + 1 >= SLOTS) ? idx_type'(0) : idx_type'(i + 1);
      end
      head  = '0;
      tail  = '0;
      fhead = idx_type'(1);
      ftail = idx_type'(SLOTS - 1);
      errors   = 0;
      n_insert = 0;
      n_delete = 0;
      foreach (n_status[i]) n_status[i] = 0;
   endfunction

   // Take the free head and link it before the first element not smaller
   function list_result_type insert_value(value_type v);
      list_result_type r;
      idx_type         s;
      idx_type         prev;
      idx_type         cur;
      int              steps;
      r.status = ST_FULL;
      r.slot   = '0;
      s = fhead;
      if (s == '0) return r;
      fhead = links[s];
      if (fhead == '0) ftail = '0;
      vals[s] = v;
      if (head == '0) begin
         links[s] = '0;
         head     = s;
         tail     = s;
      end else if (v <= vals[head]) begin
         links[s] = head;
         head     = s;
      end else if (v > vals[tail]) begin
         links[s]    = '0;
         links[tail] = s;
         tail        = s;
      end else begin
         prev  = head;
         cur   = links[head];
         steps = 0;
         while (cur != '0 && v > vals[cur] && steps < SLOTS) begin
            prev = cur;
            cur  = links[cur];
            steps++;
         end
         links[s]    = cur;
         links[prev] = s;
         if (cur == '0) tail = s;
      end
      r.status = ST_DONE;
      r.slot   = s;
      return r;
   endfunction

   // Unlink the first equal element; a freed head slot goes on the free head
   function list_result_type delete_value(value_type v);
      list_result_type r;
      idx_type         prev;
      idx_type         cur;
      int              steps;
      r.status = ST_EMPTY;
      r.slot   = '0;
      if (head == '0) return r;
      if (vals[head] == v) begin
         cur  = head;
         head = links[cur];
         if (head == '0) tail = '0;
         links[cur] = fhead;
         fhead      = cur;
         if (ftail == '0) ftail = cur;
         r.status = ST_DONE;
         r.slot   = cur;
         return r;
      end
      prev  = head;
      cur   = links[head];
      steps = 0;
      while (cur != '0 && vals[cur] < v && steps < SLOTS) begin
         prev = cur;
         cur  = links[cur];
         steps++;
      end
      r.status = ST_NOT_FOUND;
      if (cur == '0 || vals[cur] != v) return r;
      links[prev] = links[cur];
      if (cur == tail) tail = prev;
      links[cur] = '0;
      if (ftail != '0) links[ftail] = cur;
      else fhead = cur;
      ftail    = cur;
      r.status = ST_DONE;
      r.slot   = cur;
      return r;
   endfunction

   // Note an accepted request and queue the result it must produce
   function void apply_request(logic op, value_type v);
      if (op == OP_INSERT) begin
         expected_results.push_back(insert_value(v));
         n_insert++;
      end else begin
         expected_results.push_back(delete_value(v));
         n_delete++;
      end
   endfunction

   // Compare a response transfer with the oldest expected result
   function void check_result(status_type status, idx_type slot);
      list_result_type exp_r;
      if (expected_results.size() == 0) begin
         $error("response with no request pending: status %0d slot %0d", status, slot);
         errors++;
         return;
      end
      exp_r = expected_results.pop_front();
      n_status[exp_r.status]++;
      if (status !== exp_r.status) begin
         $error("status: expected %0d, actual %0d", exp_r.status, status);
         errors++;
      end
      if (slot !== exp_r.slot) begin
         $error("slot: expected %0d, actual %0d", exp_r.slot, slot);
         errors++;
      end
   endfunction

   // Pick the value of a random element currently in the list
   function value_type listed_value();
      idx_type walk;
      int      n;
      int      pick;
      n    = 0;
      walk = head;
      while (walk != '0 && n < SLOTS) begin
         walk = links[walk];
         n++;
      end
      if (n == 0) return value_type'($urandom());
      pick = $urandom_range(n - 1);
      walk = head;
      for (int i = 0; i < pick; i++) walk = links[walk];
      return vals[walk];
   endfunction
endclass

module tb;
   logic clock;
   logic reset;
   bit   idling_on;

   sall_req_if req_bus ();
   sall_rsp_if rsp_bus ();

   list_mirror mirror = new();

   sorted_array_linked_list u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Check response transfers, then stall the response side at random while idling is on
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            mirror.check_result(rsp_bus.status, rsp_bus.slot);
         rsp_bus.ready <= !idling_on || ($urandom_range(99) >= 17);
      end
   end

   // Present one request and hold it until the transfer
   task automatic send_op(input logic op, input value_type v);
      while (idling_on && $urandom_range(99) < 17) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      mirror.apply_request(op, v);
   endtask

   // Hold off new requests until every expected result has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (mirror.expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic value_type random_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return value_type'(int'($urandom_range(8)) - 4);
         4: begin
            case ($urandom_range(3))
               0: return value_type'(16'sh8000);
               1: return value_type'(16'sh7fff);
               2: return value_type'(0);
               default: return value_type'(-1);
            endcase
         end
         default: return value_type'($urandom());
      endcase
   endfunction

   // Time limit for the whole run
   initial begin
      #10_000_000;
      $display("[sorted_array_linked_list] ERROR");
      $finish;
   end

   initial begin
      value_type fill_vals[11];
      logic      op;
      value_type v;
      int        insert_pct;

      fill_vals = '{-1, -32768, 5, -5, 1, 2, 3, -2, 7, 32767, 100};
      reset         <= 1'b1;
      idling_on     <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op    <= OP_INSERT;
      req_bus.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, head, tail, middle, duplicates, not found
      send_op(OP_DELETE, 5);
      send_op(OP_INSERT, 0);
      send_op(OP_INSERT, 0);
      send_op(OP_INSERT, 32767);
      send_op(OP_INSERT, -32768);
      send_op(OP_INSERT, 100);
      send_op(OP_INSERT, 100);
      send_op(OP_DELETE, 50);
      send_op(OP_DELETE, 100);
      send_op(OP_DELETE, -32768);
      // Fill the store, overflow it, then free slots with the free list drained
      foreach (fill_vals[i]) send_op(OP_INSERT, fill_vals[i]);
      send_op(OP_INSERT, 12);
      send_op(OP_DELETE, 32767);
      send_op(OP_INSERT, 9);
      send_op(OP_DELETE, -32768);
      drain_results();

      // Random: alternate insert-heavy and delete-heavy phases
      for (int i = 0; i < 950; i++) begin
         if (i == 300) idling_on <= 1'b0;
         if (i == 450) idling_on <= 1'b1;
         if (i % 200 == 100) drain_results();
         insert_pct = ((i / 80) % 2 == 0) ? 70 : 30;
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
         if (op == OP_DELETE && $urandom_range(99) < 70) v = mirror.listed_value();
         else v = random_value();
         send_op(op, v);
      end
      req_bus.valid <= 1'b0;

      // Let the last results arrive, then watch for strays
      while (mirror.expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d inserts and %0d deletes", mirror.n_insert, mirror.n_delete);
      $display("results: %0d done, %0d full, %0d not found, %0d empty",
               mirror.n_status[ST_DONE], mirror.n_status[ST_FULL],
               mirror.n_status[ST_NOT_FOUND], mirror.n_status[ST_EMPTY]);
      if (mirror.errors == 0) begin
         $display("[sorted_array_linked_list] OK");
      end else begin
         $display("[sorted_array_linked_list] ERROR");
      end
      $finish;
   end
endmodule
